// ===== hdl/tmn_pkg.sv =====
// ----------------------------------------------------------------------------
// tmn_pkg
// Types, constants and helpers shared by the token mutex node files.
// ----------------------------------------------------------------------------
package tmn_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int SEQ_W     = 16;
  localparam int QLEN_W    = $clog2(MAX_NODES + 1);
  localparam int NUM_W     = 5;
  localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_LOCAL   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_REMOTE  = 2'd2,
    REQ_ELEM    = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    MSG_BCAST = 2'd0,
    MSG_ELEM  = 2'd1,
    MSG_GRANT = 2'd2
  } msg_kind_t;

  typedef enum logic [1:0] {
    CFG_NODE_ID = 2'd0,
    CFG_NUM     = 2'd1,
    CFG_HOLDER  = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_CHECK,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NODE_W-1:0] from_node;
    logic [SEQ_W-1:0]  req_seq;
    logic [NODE_W-1:0] elem_index;
    logic [SEQ_W-1:0]  elem_served;
    logic [NODE_W-1:0] elem_queue_node;
    logic              elem_queue_valid;
    logic              elem_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        msg_kind;
    logic [NODE_W-1:0] dest_node;
    logic [NODE_W-1:0] bcast_node;
    logic [SEQ_W-1:0]  bcast_seq;
    logic [NODE_W-1:0] out_index;
    logic [SEQ_W-1:0]  out_served;
    logic [NODE_W-1:0] out_queue_node;
    logic              out_queue_valid;
    logic              out_last;
  } out_item_t;

  typedef struct packed {
    logic              req_we;
    logic [SEQ_W-1:0]  req_val;
    logic              srv_we;
    logic [SEQ_W-1:0]  srv_val;
    logic              wq_we;
    logic [NODE_W-1:0] wq_val;
    logic              shift;
  } cell_ctrl_t;

  function automatic logic is_fresh(input logic [SEQ_W-1:0] req,
                                    input logic [SEQ_W-1:0] srv);
    return (srv != SEQ_MAX) && (req == srv + 1'b1);
  endfunction

  function automatic logic [NUM_W-1:0] nodes_in_use(input logic [NUM_W-1:0] n);
    logic [NUM_W-1:0] r;
    r = n;
    if (r == '0) r = NUM_W'(1);
    if (r > NUM_W'(MAX_NODES)) r = NUM_W'(MAX_NODES);
    return r;
  endfunction

endpackage

// ===== hdl/tmn_cell.sv =====
// ----------------------------------------------------------------------------
// tmn_cell
// One node slot: request number, served number and one wait queue entry;
// the queue entry takes its neighbor's value on a pop.
// ----------------------------------------------------------------------------
module tmn_cell
  import tmn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [NODE_W-1:0] nb_wq,
  output logic [SEQ_W-1:0]  req,
  output logic [SEQ_W-1:0]  srv,
  output logic [NODE_W-1:0] wq
);

  logic [SEQ_W-1:0]  req_r;
  logic [SEQ_W-1:0]  srv_r;
  logic [NODE_W-1:0] wq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0;
      srv_r <= '0;
    end else begin
      if (ctrl.req_we) req_r <= ctrl.req_val;
      if (ctrl.srv_we) srv_r <= ctrl.srv_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      wq_r <= nb_wq;
    end else if (ctrl.wq_we) begin
      wq_r <= ctrl.wq_val;
    end
  end

  assign req = req_r;
  assign srv = srv_r;
  assign wq  = wq_r;

endmodule

// ===== hdl/token_mutex_node.sv =====
// ----------------------------------------------------------------------------
// token_mutex_node
// One node of token-based distributed mutual exclusion.
// ----------------------------------------------------------------------------
// Usage: raise start with an item on in_item while busy is low; the item is
// taken at that edge. Results appear on out_item for one cycle each, marked
// by out_valid; out_item.out_last flags the last result of a run. The
// receiver cannot stall, so results are never held back.
// A local request or the last token element gives one result in the next
// cycle, with busy staying low. A release by the token holder walks the
// node cells one per cycle, then pops the queue; on an empty queue the
// token stays idle, else it sends one token element per cycle, the last
// element out in the cycle in which busy falls.
// A remote request passes a check state, plus num_nodes elements if the
// idle token leaves. The cfg channel is always ready; writes to node_id or
// initial_holder reload the token flags. Reset clears the tables, the queue
// length and the sequence number; the node holding the token is node 0.
// ----------------------------------------------------------------------------
module token_mutex_node
  import tmn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [NUM_W-1:0] cfg_data
);

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] idx_r, idx_nxt;
  logic [NODE_W-1:0] dest_r, dest_nxt;
  logic [QLEN_W-1:0] qlen_r, qlen_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic              holds_r, holds_nxt;
  logic              idle_r, idle_nxt;
  logic [NODE_W-1:0] node_id_r, node_id_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [NODE_W-1:0] holder_r, holder_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  cell_ctrl_t        ctrl [MAX_NODES];
  logic [SEQ_W-1:0]  req_a [MAX_NODES];
  logic [SEQ_W-1:0]  srv_a [MAX_NODES];
  logic [NODE_W-1:0] wq_a  [MAX_NODES];
  logic [MAX_NODES-1:0] hit;

  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    logic [NODE_W-1:0] nb;
    if (g == MAX_NODES - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = wq_a[g+1];
    end
    tmn_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl[g]),
      .nb_wq (nb),
      .req   (req_a[g]),
      .srv   (srv_a[g]),
      .wq    (wq_a[g])
    );
    assign hit[g] = (QLEN_W'(g) < qlen_r) && (wq_a[g] == idx_r);
  end

  logic [NUM_W-1:0]  n_use;
  logic [SEQ_W-1:0]  seq_inc;
  logic [QLEN_W-1:0] qlen_tmp;
  logic              send_last;

  assign n_use     = nodes_in_use(num_r);
  assign seq_inc   = (seq_r != SEQ_MAX) ? seq_r + 1'b1 : seq_r;
  assign send_last = (NUM_W'(idx_r) + 1'b1) == n_use;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    dest_nxt      = dest_r;
    qlen_nxt      = qlen_r;
    seq_nxt       = seq_r;
    holds_nxt     = holds_r;
    idle_nxt      = idle_r;
    node_id_nxt   = node_id_r;
    num_nxt       = num_r;
    holder_nxt    = holder_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    qlen_tmp      = qlen_r;
    for (int k = 0; k < MAX_NODES; k++) ctrl[k] = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (req_type_t'(in_item.req_type))
            REQ_LOCAL: begin
              idle_nxt = 1'b0;
              seq_nxt  = seq_inc;
              ctrl[node_id_r].req_we  = 1'b1;
              ctrl[node_id_r].req_val = seq_inc;
              out_nxt = '0;
              out_nxt.out_last = 1'b1;
              if (holds_r) begin
                out_nxt.msg_kind = MSG_GRANT;
              end else begin
                out_nxt.msg_kind   = MSG_BCAST;
                out_nxt.bcast_node = node_id_r;
                out_nxt.bcast_seq  = seq_inc;
              end
              out_valid_nxt = 1'b1;
            end
            REQ_RELEASE: begin
              if (holds_r) begin
                ctrl[node_id_r].srv_we  = 1'b1;
                ctrl[node_id_r].srv_val = req_a[node_id_r];
                idx_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            REQ_REMOTE: begin
              if (in_item.req_seq > req_a[in_item.from_node]) begin
                ctrl[in_item.from_node].req_we  = 1'b1;
                ctrl[in_item.from_node].req_val = in_item.req_seq;
              end
              dest_nxt  = in_item.from_node;
              state_nxt = ST_CHECK;
            end
            REQ_ELEM: begin
              if (in_item.elem_index == '0) qlen_tmp = '0;
              ctrl[in_item.elem_index].srv_we  = 1'b1;
              ctrl[in_item.elem_index].srv_val = in_item.elem_served;
              ctrl[in_item.elem_index].wq_we   = 1'b1;
              ctrl[in_item.elem_index].wq_val  = in_item.elem_queue_node;
              if (in_item.elem_queue_valid &&
                  qlen_tmp < QLEN_W'(in_item.elem_index) + 1'b1) begin
                qlen_tmp = QLEN_W'(in_item.elem_index) + 1'b1;
              end
              qlen_nxt = qlen_tmp;
              if (in_item.elem_last) begin
                holds_nxt        = 1'b1;
                out_nxt          = '0;
                out_nxt.msg_kind = MSG_GRANT;
                out_nxt.out_last = 1'b1;
                out_valid_nxt    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (is_fresh(req_a[idx_r], srv_a[idx_r]) && (hit == '0) &&
            qlen_r < QLEN_W'(MAX_NODES)) begin
          ctrl[qlen_r[NODE_W-1:0]].wq_we  = 1'b1;
          ctrl[qlen_r[NODE_W-1:0]].wq_val = idx_r;
          qlen_nxt = qlen_r + 1'b1;
        end
        if (send_last) state_nxt = ST_POP;
        else idx_nxt = idx_r + 1'b1;
      end
      ST_POP: begin
        if (qlen_r == '0) begin
          idle_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          dest_nxt = wq_a[0];
          for (int k = 0; k < MAX_NODES; k++) ctrl[k].shift = 1'b1;
          qlen_nxt  = qlen_r - 1'b1;
          holds_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = ST_SEND;
        end
      end
      ST_CHECK: begin
        if (holds_r && idle_r && is_fresh(req_a[dest_r], srv_a[dest_r])) begin
          holds_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = ST_SEND;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEND: begin
        out_nxt = '0;
        out_nxt.msg_kind   = MSG_ELEM;
        out_nxt.dest_node  = dest_r;
        out_nxt.out_index  = idx_r;
        out_nxt.out_served = srv_a[idx_r];
        if (QLEN_W'(idx_r) < qlen_r) begin
          out_nxt.out_queue_valid = 1'b1;
          out_nxt.out_queue_node  = wq_a[idx_r];
        end
        out_nxt.out_last = send_last;
        out_valid_nxt    = 1'b1;
        if (send_last) state_nxt = ST_IDLE;
        else idx_nxt = idx_r + 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_NODE_ID: begin
          node_id_nxt = cfg_data[NODE_W-1:0];
          holds_nxt   = (cfg_data[NODE_W-1:0] == holder_r);
          idle_nxt    = holds_nxt;
        end
        CFG_NUM: num_nxt = cfg_data;
        CFG_HOLDER: begin
          holder_nxt = cfg_data[NODE_W-1:0];
          holds_nxt  = (cfg_data[NODE_W-1:0] == node_id_r);
          idle_nxt   = holds_nxt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      qlen_r      <= '0;
      seq_r       <= '0;
      holds_r     <= 1'b1;
      idle_r      <= 1'b1;
      node_id_r   <= '0;
      num_r       <= NUM_W'(MAX_NODES);
      holder_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qlen_r      <= qlen_nxt;
      seq_r       <= seq_nxt;
      holds_r     <= holds_nxt;
      idle_r      <= idle_nxt;
      node_id_r   <= node_id_nxt;
      num_r       <= num_nxt;
      holder_r    <= holder_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    dest_r <= dest_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
  a_qlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qlen_r <= QLEN_W'(MAX_NODES))
    else $error("queue length above node count");

  a_elem_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.msg_kind == MSG_ELEM |-> !holds_r)
    else $error("token element sent while token still held");

  a_local_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.req_type == REQ_LOCAL |=> out_valid)
    else $error("local request gave no result");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.out_last |=> out_valid && out_item.msg_kind == MSG_ELEM)
    else $error("token run broken");
`endif

endmodule
